// ----- design/slmp_pkg.sv -----
// Shared constants, types and command/status structs for the sparse linear predictor.
`timescale 1ns / 1ps

package slmp_pkg;

  // Sizing
  localparam int MAX_FEATURES = 4096;
  localparam int MAX_GROUPS   = 8;
  localparam int FRAC_BITS    = 16;

  localparam int DATA_W   = 32;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int PRED_W   = ACC_W + 2;
  localparam int FEAT_W   = $clog2(MAX_FEATURES);
  localparam int GRP_W    = $clog2(MAX_GROUPS);
  localparam int ADDR_W   = FEAT_W + GRP_W;
  localparam int FIDX_W   = 24;
  localparam int GSEL_W   = 3;
  localparam int FCNT_W   = 13;
  localparam int GCNT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W    = GRP_W + 1;

  // Multiply-accumulate sequence: reads issued, then two pipeline stages drain
  localparam int MAC_DRAIN = 2;
  localparam logic [CNT_W-1:0] MAC_LAST_CNT = CNT_W'(MAX_GROUPS + MAC_DRAIN - 1);

  // Reset values of the configuration registers
  localparam logic [FCNT_W-1:0] FEATURE_COUNT_RST = FCNT_W'(4096);
  localparam logic [GCNT_W-1:0] GROUP_COUNT_RST   = GCNT_W'(1);

  // Input operation codes
  typedef enum logic [2:0] {
    OP_LOAD_WEIGHT = 3'd0,
    OP_LOAD_BIAS   = 3'd1,
    OP_SET_MARGIN  = 3'd2,
    OP_FEATURE     = 3'd3,
    OP_END_ROW     = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURE_COUNT  = 2'd0,
    CFG_GROUP_COUNT    = 2'd1,
    CFG_DEFAULT_MARGIN = 2'd2
  } cfg_idx_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic             load_weight;
    logic             load_bias;
    logic             set_margin;
    logic             latch_entry;
    logic             mac_issue;
    logic [GRP_W-1:0] mac_k;
    logic             emit;
    logic [GRP_W-1:0] emit_k;
    logic             emit_last;
    logic             clear_row;
  } slmp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic             out_free;
    logic             entry_hit;
    logic [GRP_W-1:0] last_k;
  } slmp_status_t;

endpackage

// ----- design/slmp_ctrl.sv -----
// Controller: sequences accepts, per-group multiply-accumulate and result emission.
`timescale 1ns / 1ps

module slmp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            op,
  input  slmp_pkg::slmp_status_t status,
  output slmp_pkg::slmp_cmd_t    cmd
);
  import slmp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  op_t              op_dec;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign op_dec   = op_t'(op);

  // Command decode
  always_comb begin
    cmd = '0;
    if (accept) begin
      case (op_dec)
        OP_LOAD_WEIGHT: cmd.load_weight = 1'b1;
        OP_LOAD_BIAS:   cmd.load_bias   = 1'b1;
        OP_SET_MARGIN:  cmd.set_margin  = 1'b1;
        OP_FEATURE:     cmd.latch_entry = 1'b1;
        default:        ;
      endcase
    end
    cmd.mac_issue = (state == ST_MAC) && (cnt < CNT_W'(MAX_GROUPS));
    cmd.mac_k     = cnt[GRP_W-1:0];
    cmd.emit      = (state == ST_EMIT) && status.out_free;
    cmd.emit_k    = cnt[GRP_W-1:0];
    cmd.emit_last = (cnt[GRP_W-1:0] == status.last_k);
    cmd.clear_row = cmd.emit && cmd.emit_last;
  end

  // State and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            if (op_dec == OP_FEATURE && status.entry_hit) begin
              state <= ST_MAC;
            end else if (op_dec == OP_END_ROW) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_MAC: begin
          if (cnt == MAC_LAST_CNT) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (cmd.emit) begin
            if (cmd.emit_last) begin
              state <= ST_IDLE;
              cnt   <= '0;
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

endmodule

// ----- design/slmp_dp.sv -----
// Datapath: config registers, weight memory, MAC pipeline, accumulators, output register.
`timescale 1ns / 1ps

module slmp_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [slmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slmp_pkg::DATA_W-1:0]    cfg_data,
  input  logic [slmp_pkg::FIDX_W-1:0]    feature_index,
  input  logic [slmp_pkg::GSEL_W-1:0]    group_sel,
  input  logic signed [slmp_pkg::DATA_W-1:0] data_value,
  input  slmp_pkg::slmp_cmd_t     cmd,
  output slmp_pkg::slmp_status_t  status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [slmp_pkg::GSEL_W-1:0]    group,
  output logic signed [slmp_pkg::DATA_W-1:0] prediction,
  output logic                    last
);
  import slmp_pkg::*;

  // Configuration registers
  logic [FCNT_W-1:0]        feature_count;
  logic [GCNT_W-1:0]        group_count;
  logic signed [DATA_W-1:0] default_margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count  <= FEATURE_COUNT_RST;
      group_count    <= GROUP_COUNT_RST;
      default_margin <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FEATURE_COUNT:  feature_count  <= cfg_data[FCNT_W-1:0];
        CFG_GROUP_COUNT:    group_count    <= cfg_data[GCNT_W-1:0];
        CFG_DEFAULT_MARGIN: default_margin <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Status: feature in range, index of the row's final group, output register free
  always_comb begin
    status.entry_hit = (feature_index < FIDX_W'(feature_count)) &&
                       (feature_index < FIDX_W'(MAX_FEATURES));
    if (group_count == '0) begin
      status.last_k = '0;
    end else if (group_count > GCNT_W'(MAX_GROUPS)) begin
      status.last_k = GRP_W'(MAX_GROUPS - 1);
    end else begin
      status.last_k = GRP_W'(group_count - GCNT_W'(1));
    end
    status.out_free = !out_valid || !out_stall;
  end

  // Weight memory, row-major by feature then group
  logic signed [DATA_W-1:0] weight_mem [2**ADDR_W];
  logic signed [DATA_W-1:0] wdata;
  logic [FEAT_W-1:0]        entry_fi;
  logic signed [DATA_W-1:0] entry_val;
  logic                     grp_ok;
  logic                     weight_ok;

  // Group select in range of the implemented groups
  assign grp_ok    = (int'(group_sel) < MAX_GROUPS);
  assign weight_ok = (feature_index < FIDX_W'(MAX_FEATURES)) && grp_ok;

  always_ff @(posedge clk) begin
    if (cmd.load_weight && weight_ok) begin
      weight_mem[{feature_index[FEAT_W-1:0], group_sel[GRP_W-1:0]}] <= data_value;
    end
    if (cmd.mac_issue) begin
      wdata <= weight_mem[{entry_fi, cmd.mac_k}];
    end
  end

  // Latch the sparse entry
  always_ff @(posedge clk) begin
    if (cmd.latch_entry) begin
      entry_fi  <= feature_index[FEAT_W-1:0];
      entry_val <= data_value;
    end
  end

  // MAC pipeline: read -> multiply -> accumulate
  logic                     rd_valid;
  logic [GRP_W-1:0]         rd_k;
  logic                     prod_valid;
  logic [GRP_W-1:0]         prod_k;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.mac_issue;
      prod_valid <= rd_valid;
    end
    rd_k   <= cmd.mac_k;
    prod_k <= rd_k;
    if (rd_valid) begin
      prod <= entry_val * wdata;
    end
  end

  // Accumulate with 48-bit saturation
  logic signed [ACC_W-1:0]  acc [MAX_GROUPS];
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_next;

  always_comb begin
    prod_sh = prod >>> FRAC_BITS;
    acc_sum = {acc[prod_k][ACC_W-1], acc[prod_k]} +
              {prod_sh[ACC_W-1], prod_sh[ACC_W-1:0]};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
  end

  // Per-group row state and biases
  logic signed [DATA_W-1:0] bias [MAX_GROUPS];
  logic signed [DATA_W-1:0] margin [MAX_GROUPS];
  logic [MAX_GROUPS-1:0]    margin_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_GROUPS; i++) begin
        acc[i]  <= '0;
        bias[i] <= '0;
      end
      margin_set <= '0;
    end else begin
      if (cmd.clear_row) begin
        for (int i = 0; i < MAX_GROUPS; i++) begin
          acc[i] <= '0;
        end
        margin_set <= '0;
      end else if (prod_valid) begin
        acc[prod_k] <= acc_next;
      end
      if (cmd.load_bias && grp_ok) begin
        bias[group_sel[GRP_W-1:0]] <= data_value;
      end
      if (cmd.set_margin && grp_ok) begin
        margin_set[group_sel[GRP_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_margin && grp_ok) begin
      margin[group_sel[GRP_W-1:0]] <= data_value;
    end
  end

  // Prediction: bias + margin + accumulator, saturated to 32 bits
  logic signed [DATA_W-1:0] m_sel;
  logic signed [PRED_W-1:0] pred_sum;
  logic signed [DATA_W-1:0] pred_sat;

  always_comb begin
    m_sel    = margin_set[cmd.emit_k] ? margin[cmd.emit_k] : default_margin;
    pred_sum = PRED_W'(bias[cmd.emit_k]) + PRED_W'(m_sel) + PRED_W'(acc[cmd.emit_k]);
    if (pred_sum > PRED_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      pred_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (pred_sum < -PRED_W'(signed'({1'b0, 1'b1, {(DATA_W-1){1'b0}}}))) begin
      pred_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      pred_sat = pred_sum[DATA_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      group      <= GSEL_W'(cmd.emit_k);
      prediction <= pred_sat;
      last       <= cmd.emit_last;
    end
  end

endmodule

// ----- design/sparse_linear_model_predict.sv -----
// Top level of the sparse multi-output linear model predictor.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    op, feature_index, group_sel, data_value
// output    out        out_valid / out_stall  group, prediction, last
// config    in         cfg_write              cfg_index, cfg_data
//
// Weight, bias, margin, skipped entries and unknown ops are taken without stalling the input.
// An in-range feature entry stalls the input for 8 weight reads from the single
// memory port, one per group, through a shared 32x32 multiplier and two drain stages.
// End of row stalls the input while one result per group is emitted; out_stall extends the stall.
// Reset (rst, synchronous) clears accumulators, biases and margin flags; weights
// are undefined until loaded. A stalled result holds in the output register.

module sparse_linear_model_predict (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [slmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slmp_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          op,
  input  logic [slmp_pkg::FIDX_W-1:0]         feature_index,
  input  logic [slmp_pkg::GSEL_W-1:0]         group_sel,
  input  logic signed [slmp_pkg::DATA_W-1:0]  data_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [slmp_pkg::GSEL_W-1:0]         group,
  output logic signed [slmp_pkg::DATA_W-1:0]  prediction,
  output logic                                last
);
  import slmp_pkg::*;

  slmp_cmd_t    cmd;
  slmp_status_t status;

  slmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  slmp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .feature_index (feature_index),
    .group_sel     (group_sel),
    .data_value    (data_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .group         (group),
    .prediction    (prediction),
    .last          (last)
  );

endmodule

// ----- sim/slmp_prediction_checker.sv -----
// Checker for the sparse linear predictor: tracks transactions, predicts results, compares them.
`timescale 1ns / 1ps

module slmp_prediction_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [slmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slmp_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [2:0]                          op,
  input  logic [slmp_pkg::FIDX_W-1:0]         feature_index,
  input  logic [slmp_pkg::GSEL_W-1:0]         group_sel,
  input  logic signed [slmp_pkg::DATA_W-1:0]  data_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [slmp_pkg::GSEL_W-1:0]         group,
  input  logic signed [slmp_pkg::DATA_W-1:0]  prediction,
  input  logic                                last,
  output int                                  fail_count,
  output int                                  pending
);
  import slmp_pkg::*;

  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint OUT_HI = 64'sd2147483647;
  localparam longint OUT_LO = -OUT_HI - 1;
  localparam int     REPORT_LIMIT = 10;

  typedef struct packed {
    logic [GSEL_W-1:0] grp;
    logic [DATA_W-1:0] pred;
    logic              lst;
  } group_pred_t;

  // Predicted results still owed by the block, oldest first
  group_pred_t owed_preds[$];

  // Shadow of the block state and its configuration
  logic signed [DATA_W-1:0] weight_mem [0:MAX_FEATURES*MAX_GROUPS-1];
  logic signed [DATA_W-1:0] bias_mem   [0:MAX_GROUPS-1];
  logic signed [ACC_W-1:0]  row_sum    [0:MAX_GROUPS-1];
  logic signed [DATA_W-1:0] row_margin [0:MAX_GROUPS-1];
  logic                     margin_set [0:MAX_GROUPS-1];
  logic [FCNT_W-1:0]        feat_cnt;
  logic [GCNT_W-1:0]        grp_cnt;
  logic signed [DATA_W-1:0] dflt_margin;

  int mismatches = 0;
  assign fail_count = mismatches;

  function automatic longint saturate(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_row();
    for (int k = 0; k < MAX_GROUPS; k++) begin
      row_sum[k]    = '0;
      row_margin[k] = '0;
      margin_set[k] = 1'b0;
    end
  endtask

  task automatic note_mismatch(input bit have_exp, input group_pred_t want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      if (have_exp)
        $display("%0t mismatch: exp group=%0d pred=%h last=%0d, got group=%0d pred=%h last=%0d",
                 $time, want.grp, want.pred, want.lst, group, prediction, last);
      else
        $display("%0t unexpected result: group=%0d pred=%h last=%0d",
                 $time, group, prediction, last);
    end
  endtask

  // Compare one accepted result transaction with the oldest prediction
  task automatic check_result();
    group_pred_t want;
    if (owed_preds.size() == 0) begin
      want = '0;
      note_mismatch(1'b0, want);
    end else begin
      want = owed_preds.pop_front();
      if (want.grp !== group || want.pred !== prediction || want.lst !== last)
        note_mismatch(1'b1, want);
    end
  endtask

  // One multiply-accumulate per group for an in-range sparse entry
  task automatic accumulate(input logic [FIDX_W-1:0] fi, input logic signed [DATA_W-1:0] v);
    int     limit;
    int     row_base;
    longint prod;
    longint sum;
    limit = (int'(feat_cnt) > MAX_FEATURES) ? MAX_FEATURES : int'(feat_cnt);
    if (fi < limit) begin
      row_base = int'(fi) * MAX_GROUPS;
      for (int k = 0; k < MAX_GROUPS; k++) begin
        prod = longint'(v) * longint'(weight_mem[row_base + k]);
        sum  = longint'(row_sum[k]) + (prod >>> FRAC_BITS);
        row_sum[k] = ACC_W'(saturate(sum, ACC_LO, ACC_HI));
      end
    end
  endtask

  // End of row: one prediction per active group, then the row state clears
  task automatic emit_row();
    int          ng;
    longint      m;
    longint      s;
    group_pred_t item;
    ng = (grp_cnt == 0) ? 1 : int'(grp_cnt);
    if (ng > MAX_GROUPS) ng = MAX_GROUPS;
    for (int k = 0; k < ng; k++) begin
      m = margin_set[k] ? longint'(row_margin[k]) : longint'(dflt_margin);
      s = saturate(longint'(bias_mem[k]) + m + longint'(row_sum[k]), OUT_LO, OUT_HI);
      item.grp  = GSEL_W'(k);
      item.pred = s[DATA_W-1:0];
      item.lst  = (k == ng - 1);
      owed_preds.push_back(item);
    end
    clear_row();
  endtask

  task automatic predict_item();
    case (op)
      OP_LOAD_WEIGHT: begin
        if (feature_index < MAX_FEATURES && group_sel < MAX_GROUPS)
          weight_mem[int'(feature_index) * MAX_GROUPS + int'(group_sel)] = data_value;
      end
      OP_LOAD_BIAS: begin
        if (group_sel < MAX_GROUPS) bias_mem[group_sel] = data_value;
      end
      OP_SET_MARGIN: begin
        if (group_sel < MAX_GROUPS) begin
          row_margin[group_sel] = data_value;
          margin_set[group_sel] = 1'b1;
        end
      end
      OP_FEATURE: accumulate(feature_index, data_value);
      OP_END_ROW: emit_row();
      default: ;
    endcase
  endtask

  task automatic write_register();
    case (cfg_index)
      CFG_FEATURE_COUNT:  feat_cnt    = cfg_data[FCNT_W-1:0];
      CFG_GROUP_COUNT:    grp_cnt     = cfg_data[GCNT_W-1:0];
      CFG_DEFAULT_MARGIN: dflt_margin = cfg_data;
      default: ;
    endcase
  endtask

  // Results are checked before the same edge's input is applied
  always @(posedge clk) begin
    if (rst) begin
      owed_preds.delete();
      clear_row();
      for (int k = 0; k < MAX_GROUPS; k++) bias_mem[k] = '0;
      feat_cnt    = FEATURE_COUNT_RST;
      grp_cnt     = GROUP_COUNT_RST;
      dflt_margin = '0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_write) write_register();
      if (in_valid && !in_stall) predict_item();
    end
    pending <= owed_preds.size();
  end

endmodule

// ----- sim/tb_sparse_linear_model_predict.sv -----
// Testbench top for the sparse linear predictor: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_sparse_linear_model_predict;
  import slmp_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int IDLE_PCT        = 36;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 24;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int PHASE_COUNT     = 7;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [DATA_W-1:0]          cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [2:0]                 op;
  logic [FIDX_W-1:0]          feature_index;
  logic [GSEL_W-1:0]          group_sel;
  logic signed [DATA_W-1:0]   data_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [GSEL_W-1:0]          group;
  logic signed [DATA_W-1:0]   prediction;
  logic                       last;

  int   fail_count;
  int   pending;
  logic calm = 1'b0;
  int   hold_req = 0;
  int   items = 0;
  int   cur_limit;

  // Which groups of each feature hold a loaded weight
  logic [MAX_GROUPS-1:0] weight_loaded [0:MAX_FEATURES-1];
  int                    live_features[$];

  sparse_linear_model_predict uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .feature_index(feature_index), .group_sel(group_sel), .data_value(data_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .group(group), .prediction(prediction), .last(last)
  );

  slmp_prediction_checker predict_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .feature_index(feature_index), .group_sel(group_sel), .data_value(data_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .group(group), .prediction(prediction), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, calm stretches, and a long hold-off on request
  initial begin : receiver
    int hold_done;
    hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_req;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Q16.16 values biased toward the extremes and small magnitudes
  function automatic logic [DATA_W-1:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4, 5: return DATA_W'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh3FFFF);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Entry index at or above the current limit, often right at the boundary
  function automatic logic [FIDX_W-1:0] skipped_index();
    logic [FIDX_W-1:0] fi;
    if ($urandom_range(0, 1)) begin
      fi = FIDX_W'(cur_limit + $urandom_range(0, 40));
    end else begin
      fi = FIDX_W'($urandom);
      while (fi < cur_limit) fi = FIDX_W'($urandom);
    end
    return fi;
  endfunction

  // Offer one input transaction and wait until it is taken
  task automatic send(input logic [2:0] o, input logic [FIDX_W-1:0] fi,
                      input logic [GSEL_W-1:0] g, input logic [DATA_W-1:0] v);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    op            <= o;
    feature_index <= fi;
    group_sel     <= g;
    data_value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items++;
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [DATA_W-1:0] d);
    int fc;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    if (idx == CFG_FEATURE_COUNT) begin
      fc = int'(d[FCNT_W-1:0]);
      cur_limit = (fc > MAX_FEATURES) ? MAX_FEATURES : fc;
    end
    @(posedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] fc, input logic [DATA_W-1:0] gc,
                           input logic [DATA_W-1:0] base);
    write_cfg(CFG_FEATURE_COUNT, fc);
    write_cfg(CFG_GROUP_COUNT, gc);
    write_cfg(CFG_DEFAULT_MARGIN, base);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every owed result, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_weight(input logic [FIDX_W-1:0] fi, input logic [GSEL_W-1:0] g,
                             input logic [DATA_W-1:0] v);
    bit was_full;
    send(OP_LOAD_WEIGHT, fi, g, v);
    if (fi < MAX_FEATURES) begin
      was_full = &weight_loaded[fi];
      weight_loaded[fi][g] = 1'b1;
      if (!was_full && &weight_loaded[fi]) live_features.push_back(int'(fi));
    end
  endtask

  task automatic load_feature(input int f);
    for (int g = 0; g < MAX_GROUPS; g++)
      load_weight(FIDX_W'(f), GSEL_W'(g), rand_q16());
  endtask

  // Fully loaded feature below the limit; loads a fresh one if none is there
  task automatic pick_live_feature(output int f);
    int cands[$];
    foreach (live_features[i])
      if (live_features[i] < cur_limit) cands.push_back(live_features[i]);
    if (cands.size() == 0) begin
      f = $urandom_range(0, cur_limit - 1);
      load_feature(f);
    end else begin
      f = cands[$urandom_range(0, cands.size() - 1)];
    end
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1))
      send(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), FIDX_W'($urandom),
           GSEL_W'($urandom), DATA_W'($urandom));
    else
      send(OP_FEATURE, skipped_index(), GSEL_W'($urandom), rand_q16());
  endtask

  // A well-formed row: margins, maybe a bias, sparse entries, end of row
  task automatic random_row();
    int f;
    repeat ($urandom_range(0, 2))
      send(OP_SET_MARGIN, FIDX_W'($urandom), GSEL_W'($urandom_range(0, 7)), rand_q16());
    if ($urandom_range(0, 3) == 0)
      send(OP_LOAD_BIAS, FIDX_W'($urandom), GSEL_W'($urandom_range(0, 7)), rand_q16());
    repeat ($urandom_range(1, 6)) begin
      if (cur_limit == 0 || $urandom_range(0, 4) == 0) begin
        send(OP_FEATURE, skipped_index(), GSEL_W'($urandom), rand_q16());
      end else begin
        pick_live_feature(f);
        send(OP_FEATURE, FIDX_W'(f), GSEL_W'($urandom), rand_q16());
      end
    end
    if ($urandom_range(0, 9) == 0) send_noise();
    send(OP_END_ROW, FIDX_W'($urandom), GSEL_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic random_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      random_row();
    else if (r < 70)
      load_feature((cur_limit > 0) ? $urandom_range(0, cur_limit - 1)
                                   : $urandom_range(0, MAX_FEATURES - 1));
    else if (r < 80)
      load_weight($urandom_range(0, 1) ? FIDX_W'($urandom_range(0, MAX_FEATURES - 1))
                                       : FIDX_W'($urandom),
                  GSEL_W'($urandom_range(0, 7)), rand_q16());
    else if (r < 90)
      send(OP_LOAD_BIAS, FIDX_W'($urandom), GSEL_W'($urandom_range(0, 7)), rand_q16());
    else
      send_noise();
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] edge_vals [0:MAX_GROUPS-1];
    int target;
    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h0000_8000};
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= CFG_FEATURE_COUNT;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    op            <= OP_LOAD_WEIGHT;
    feature_index <= '0;
    group_sel     <= '0;
    data_value    <= '0;
    for (int i = 0; i < MAX_FEATURES; i++) weight_loaded[i] = '0;
    cur_limit = MAX_FEATURES;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme weights on the first and last feature
    configure(32'd4096, 32'd8, 32'd0);
    for (int g = 0; g < MAX_GROUPS; g++)
      load_weight(FIDX_W'(0), GSEL_W'(g), edge_vals[g]);
    for (int g = 0; g < MAX_GROUPS; g++)
      load_weight(FIDX_W'(MAX_FEATURES - 1), GSEL_W'(g), edge_vals[MAX_GROUPS - 1 - g]);
    // Bias and margin extremes, accumulator saturation, skipped and ignored items
    send(OP_LOAD_BIAS, FIDX_W'(0), GSEL_W'(0), 32'h7FFF_FFFF);
    send(OP_LOAD_BIAS, FIDX_W'(0), GSEL_W'(7), 32'h8000_0000);
    send(OP_SET_MARGIN, FIDX_W'(0), GSEL_W'(1), 32'h8000_0000);
    send(OP_FEATURE, FIDX_W'(0), GSEL_W'(0), 32'h7FFF_FFFF);
    send(OP_FEATURE, FIDX_W'(0), GSEL_W'(0), 32'h7FFF_FFFF);
    send(OP_FEATURE, FIDX_W'(MAX_FEATURES - 1), GSEL_W'(0), 32'h8000_0000);
    send(OP_FEATURE, FIDX_W'(MAX_FEATURES), GSEL_W'(0), 32'h7FFF_FFFF);
    send(OP_LOAD_WEIGHT, FIDX_W'(MAX_FEATURES), GSEL_W'(3), 32'h5555_AAAA);
    send(OP_SPARE_FIRST, 24'hFF_FFFF, GSEL_W'(7), 32'hFFFF_FFFF);
    send(OP_SPARE_LAST, 24'hAA_AAAA, GSEL_W'(5), 32'hAAAA_AAAA);
    send(OP_END_ROW, 24'h55_5555, GSEL_W'(2), 32'h5555_5555);
    settle();

    // Random phases, each under its own register setting
    for (int p = 1; p <= PHASE_COUNT; p++) begin
      case (p)
        1: configure(32'd4096, 32'd8, 32'h7FFF_FFFF);
        2: configure(32'd1, 32'd0, 32'h8000_0000);
        3: configure(32'd0, 32'd15, rand_q16());
        4: configure(32'd8191, 32'd3, rand_q16());
        5: configure($urandom_range(1, 4096), $urandom_range(1, 8), rand_q16());
        6: configure(32'd100, 32'd8, rand_q16());
        default: configure($urandom_range(0, 8191), $urandom_range(0, 15), rand_q16());
      endcase
      calm <= (p == 1);
      @(posedge clk);
      target = items + ITEMS_PER_PHASE;
      while (items < target) random_action();
      if (p == 1) begin
        // Receiver holds off while full rows keep coming, so the input backs up
        hold_req <= hold_req + 1;
        repeat (4) begin
          send(OP_FEATURE, FIDX_W'(0), GSEL_W'(0), rand_q16());
          send(OP_FEATURE, FIDX_W'(MAX_FEATURES - 1), GSEL_W'(0), rand_q16());
          send(OP_END_ROW, FIDX_W'($urandom), GSEL_W'($urandom), DATA_W'($urandom));
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
